// ===== design/timed_latching_relay_driver_assert.svh =====
// Assertion macros for the timed latching relay driver.
// Included by the top level; needs nothing else.
`ifndef TIMED_LATCHING_RELAY_DRIVER_ASSERT_SVH
`define TIMED_LATCHING_RELAY_DRIVER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TLRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define TLRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tlrd_pkg.sv =====
// Shared types and constants of the timed latching relay driver.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package tlrd_pkg;

  localparam int NUM_RELAYS = 2;
  localparam int DUR_W      = 16;
  localparam int COUNT_W    = 32;
  localparam int PULSE_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COIL_PULSE_MS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATCHING_MODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ACTIVE_LOW = 2'd2;

  // Reset values of the configuration registers
  localparam logic [PULSE_W-1:0] COIL_PULSE_RESET = 8'd80;

  // Item function codes
  localparam logic FUNC_COMMAND = 1'b0;
  localparam logic FUNC_TICK    = 1'b1;

  // Relay select code that names no relay
  localparam logic [NUM_RELAYS-1:0] SEL_NONE = 2'd0;

  typedef struct packed {
    logic [PULSE_W-1:0] coil_pulse_ms;
    logic               latching_mode;
    logic               output_active_low;
  } tlrd_cfg_t;

  // Per-relay view of one step
  typedef struct packed {
    logic             is_tick;
    logic             hit;
    logic             activate;
    logic [DUR_W-1:0] on_time;
  } tlrd_cmd_t;

  typedef struct packed {
    logic               on;
    logic               armed;
    logic [DUR_W-1:0]   time_left;
    logic [COUNT_W-1:0] count;
    logic [PULSE_W-1:0] set_pulse;
    logic [PULSE_W-1:0] reset_pulse;
  } tlrd_relay_state_t;

  typedef struct packed {
    logic [NUM_RELAYS-1:0] relay_active;
    logic [NUM_RELAYS-1:0] set_drive;
    logic [NUM_RELAYS-1:0] reset_drive;
    logic [DUR_W-1:0]      remaining_first;
    logic [DUR_W-1:0]      remaining_second;
    logic [COUNT_W-1:0]    activations_first;
    logic [COUNT_W-1:0]    activations_second;
    logic                  bad_command;
  } tlrd_result_t;

endpackage

// ===== design/tlrd_relay.sv =====
// State record and next-state logic of one relay.
// Depends on tlrd_pkg.
`timescale 1ns / 1ps

module tlrd_relay (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_en,
  input  logic [tlrd_pkg::PULSE_W-1:0] startup_pulse,
  input  tlrd_pkg::tlrd_cfg_t         cfg,
  input  tlrd_pkg::tlrd_cmd_t         cmd,
  output tlrd_pkg::tlrd_relay_state_t state_next
);
  import tlrd_pkg::*;

  tlrd_relay_state_t state;
  logic [DUR_W-1:0]  tl_dec;

  // Saturating timer decrement
  assign tl_dec = (state.time_left != '0) ? state.time_left - 1'b1 : state.time_left;

  // Next state for a tick or for a command aimed at this relay
  always_comb begin
    state_next = state;
    if (step_en) begin
      if (cmd.is_tick) begin
        if (state.set_pulse != '0) state_next.set_pulse = state.set_pulse - 1'b1;
        if (state.reset_pulse != '0) state_next.reset_pulse = state.reset_pulse - 1'b1;
        if (state.armed && state.on) begin
          state_next.time_left = tl_dec;
          if (tl_dec == '0) begin
            // timer ran out: switch off
            state_next.on    = 1'b0;
            state_next.armed = 1'b0;
            if (cfg.latching_mode) begin
              state_next.reset_pulse = cfg.coil_pulse_ms;
              state_next.set_pulse   = '0;
            end
          end
        end
      end else if (cmd.hit) begin
        if (cfg.latching_mode) begin
          state_next.set_pulse   = cmd.activate ? cfg.coil_pulse_ms : '0;
          state_next.reset_pulse = cmd.activate ? '0 : cfg.coil_pulse_ms;
        end
        if (cmd.activate) begin
          state_next.on        = 1'b1;
          state_next.count     = state.count + 1'b1;
          state_next.armed     = (cmd.on_time != '0);
          state_next.time_left = cmd.on_time;
        end else begin
          state_next.on        = 1'b0;
          state_next.armed     = 1'b0;
          state_next.time_left = '0;
        end
      end
    end
  end

  // State register; reset coil pulses at startup
  always_ff @(posedge clk) begin
    if (rst) begin
      state.on          <= 1'b0;
      state.armed       <= 1'b0;
      state.time_left   <= '0;
      state.count       <= '0;
      state.set_pulse   <= '0;
      state.reset_pulse <= startup_pulse;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/tlrd_out_queue.sv =====
// Two-entry result queue: output register plus skid register.
// Depends on tlrd_pkg.
`timescale 1ns / 1ps

module tlrd_out_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tlrd_pkg::tlrd_result_t push_data,
  output logic                   room,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tlrd_pkg::tlrd_result_t out_data
);
  import tlrd_pkg::*;

  logic         o_valid;
  tlrd_result_t o_data;
  logic         k_valid;
  tlrd_result_t k_data;
  logic         take;

  assign take      = o_valid && !out_stall;
  assign room      = !k_valid;
  assign out_valid = o_valid;
  assign out_data  = o_data;

  // Push goes to the output register when it frees up, else to the skid
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      k_valid <= 1'b0;
    end else if (push) begin
      if (!o_valid || (take && !k_valid)) begin
        o_data  <= push_data;
        o_valid <= 1'b1;
      end else if (take) begin
        o_data <= k_data;
        k_data <= push_data;
      end else begin
        k_data  <= push_data;
        k_valid <= 1'b1;
      end
    end else if (take) begin
      if (k_valid) begin
        o_data  <= k_data;
        k_valid <= 1'b0;
      end else begin
        o_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/timed_latching_relay_driver.sv =====
// Timed latching relay driver, two relays.
// Uses an input register, two relay records, a two-entry result queue.
//
// Input channel (in_valid / in_stall): func 0 is a relay command
// (relay_select, activate, on_time), func 1 a one millisecond tick.
// Every transfer yields exactly one result on the output channel
// (out_valid / out_stall) showing both relays after that step.
// Configuration: cfg_index 0 coil pulse length, 1 latching mode,
// 2 active-low level outputs; cfg_ready is always high, index 3 is ignored.
// Write configuration only while no result is outstanding.
// An item is held in the input register, and its result in the queue's
// output register before it goes out. Throughput: one item per cycle
// while the result queue has room, which out_stall can take away.
// The skid register lets one result wait while the next item is taken;
// in_stall rises once both result registers are full and the input
// register holds an item.
// Reset: relays off, counters zero, both reset coils pulse for
// STARTUP_PULSE_MS ticks, registers at 80 ms pulse, latching, active high.
// Depends on tlrd_pkg, tlrd_relay, tlrd_out_queue and the assert header.
`timescale 1ns / 1ps

module timed_latching_relay_driver #(
  parameter int STARTUP_PULSE_MS = 50
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           func,
  input  logic [tlrd_pkg::NUM_RELAYS-1:0] relay_select,
  input  logic                           activate,
  input  logic [tlrd_pkg::DUR_W-1:0]      on_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tlrd_pkg::NUM_RELAYS-1:0] relay_active,
  output logic [tlrd_pkg::NUM_RELAYS-1:0] set_drive,
  output logic [tlrd_pkg::NUM_RELAYS-1:0] reset_drive,
  output logic [tlrd_pkg::DUR_W-1:0]      remaining_first,
  output logic [tlrd_pkg::DUR_W-1:0]      remaining_second,
  output logic [tlrd_pkg::COUNT_W-1:0]    activations_first,
  output logic [tlrd_pkg::COUNT_W-1:0]    activations_second,
  output logic                           bad_command,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tlrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlrd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tlrd_pkg::*;

  localparam logic [PULSE_W-1:0] StartupPulse = PULSE_W'(STARTUP_PULSE_MS);

  tlrd_cfg_t             cfg;
  logic                  s1_valid;
  logic                  s1_func;
  logic [NUM_RELAYS-1:0] s1_sel;
  logic                  s1_act;
  logic [DUR_W-1:0]      s1_dur;
  logic                  s1_advance;
  logic                  in_take;
  logic                  q_room;
  tlrd_cmd_t             cmd [NUM_RELAYS];
  tlrd_relay_state_t     nxt [NUM_RELAYS];
  tlrd_result_t          res;
  tlrd_result_t          q_data;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coil_pulse_ms     <= COIL_PULSE_RESET;
      cfg.latching_mode     <= 1'b1;
      cfg.output_active_low <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COIL_PULSE_MS:     cfg.coil_pulse_ms     <= cfg_data;
        REG_LATCHING_MODE:     cfg.latching_mode     <= cfg_data[0];
        REG_OUTPUT_ACTIVE_LOW: cfg.output_active_low <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register
  assign s1_advance = s1_valid && q_room;
  assign in_stall   = s1_valid && !q_room;
  assign in_take    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
        s1_func  <= func;
        s1_sel   <= relay_select;
        s1_act   <= activate;
        s1_dur   <= on_time;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Relay records
  for (genvar r = 0; r < NUM_RELAYS; r++) begin : g_relay
    assign cmd[r].is_tick     = (s1_func == FUNC_TICK);
    assign cmd[r].hit         = (s1_func == FUNC_COMMAND) && s1_sel[r];
    assign cmd[r].activate    = s1_act;
    assign cmd[r].on_time     = s1_dur;

    tlrd_relay u_relay (
      .clk           (clk),
      .rst           (rst),
      .step_en       (s1_advance),
      .startup_pulse (StartupPulse),
      .cfg           (cfg),
      .cmd           (cmd[r]),
      .state_next    (nxt[r])
    );

    // Drive outputs from the updated record
    assign res.relay_active[r] = nxt[r].on;
    assign res.set_drive[r]    = cfg.latching_mode ? (nxt[r].set_pulse != '0)
                                                   : (nxt[r].on ^ cfg.output_active_low);
    assign res.reset_drive[r]  = cfg.latching_mode && (nxt[r].reset_pulse != '0);
  end

  assign res.remaining_first    = nxt[0].armed ? nxt[0].time_left : '0;
  assign res.remaining_second   = nxt[1].armed ? nxt[1].time_left : '0;
  assign res.activations_first  = nxt[0].count;
  assign res.activations_second = nxt[1].count;
  assign res.bad_command        = (s1_func == FUNC_COMMAND) && (s1_sel == SEL_NONE);

  // Result queue
  tlrd_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_advance),
    .push_data (res),
    .room      (q_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (q_data)
  );

  assign relay_active       = q_data.relay_active;
  assign set_drive          = q_data.set_drive;
  assign reset_drive        = q_data.reset_drive;
  assign remaining_first    = q_data.remaining_first;
  assign remaining_second   = q_data.remaining_second;
  assign activations_first  = q_data.activations_first;
  assign activations_second = q_data.activations_second;
  assign bad_command        = q_data.bad_command;

  // Checks
  `include "timed_latching_relay_driver_assert.svh"

  `TLRD_ASSERT_NOW(a_full_queue_shows, clk, rst, !q_room, out_valid, "skid full, output empty")
  `TLRD_ASSERT_NEXT(a_step_gives_result, clk, rst, s1_advance, out_valid, "step lost its result")
  `TLRD_ASSERT_NOW(a_armed_means_on, clk, rst, nxt[0].armed || nxt[1].armed,
    (!nxt[0].armed || nxt[0].on) && (!nxt[1].armed || nxt[1].on), "timer armed on an off relay")
  `TLRD_ASSERT_NOW(a_armed_time_left, clk, rst, nxt[0].armed || nxt[1].armed,
    (!nxt[0].armed || nxt[0].time_left != '0) && (!nxt[1].armed || nxt[1].time_left != '0),
    "armed timer at zero")

endmodule

// ===== test/tlrd_checker.sv =====
// Status checker for the timed latching relay driver: predicts the relay status
// after every transferred item and compares it with each result transfer.
// Depends on tlrd_pkg for the configuration, result types and codes.
`timescale 1ns / 1ps

module tlrd_checker #(
  parameter int STARTUP_PULSE_MS = 50
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            func,
  input  logic [tlrd_pkg::NUM_RELAYS-1:0] relay_select,
  input  logic                            activate,
  input  logic [tlrd_pkg::DUR_W-1:0]      on_time,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [tlrd_pkg::NUM_RELAYS-1:0] relay_active,
  input  logic [tlrd_pkg::NUM_RELAYS-1:0] set_drive,
  input  logic [tlrd_pkg::NUM_RELAYS-1:0] reset_drive,
  input  logic [tlrd_pkg::DUR_W-1:0]      remaining_first,
  input  logic [tlrd_pkg::DUR_W-1:0]      remaining_second,
  input  logic [tlrd_pkg::COUNT_W-1:0]    activations_first,
  input  logic [tlrd_pkg::COUNT_W-1:0]    activations_second,
  input  logic                            bad_command,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [tlrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlrd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              outstanding,
  output int                              results_seen
);

  // Predicted configuration and relay records
  tlrd_pkg::tlrd_cfg_t          cfg;
  logic                         relay_on    [tlrd_pkg::NUM_RELAYS];
  logic                         timer_armed [tlrd_pkg::NUM_RELAYS];
  logic [tlrd_pkg::DUR_W-1:0]   time_left   [tlrd_pkg::NUM_RELAYS];
  logic [tlrd_pkg::COUNT_W-1:0] on_count    [tlrd_pkg::NUM_RELAYS];
  logic [tlrd_pkg::PULSE_W-1:0] set_left    [tlrd_pkg::NUM_RELAYS];
  logic [tlrd_pkg::PULSE_W-1:0] reset_left  [tlrd_pkg::NUM_RELAYS];

  // Relay status expected from the block, oldest first
  tlrd_pkg::tlrd_result_t relay_status_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40)
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
               $realtime, results_seen, what, got, want);
    fail_count++;
  endtask

  // Switch one relay; in latching mode the matching coil pulse is armed
  task automatic drive_relay(input int r, input logic on, input logic [15:0] dur);
    if (cfg.latching_mode) begin
      if (on) begin
        set_left[r]   = cfg.coil_pulse_ms;
        reset_left[r] = '0;
      end else begin
        reset_left[r] = cfg.coil_pulse_ms;
        set_left[r]   = '0;
      end
    end
    if (on) begin
      relay_on[r]    = 1'b1;
      on_count[r]    = on_count[r] + 32'd1;
      timer_armed[r] = (dur != '0);
      time_left[r]   = dur;
    end else begin
      relay_on[r]    = 1'b0;
      timer_armed[r] = 1'b0;
      time_left[r]   = '0;
    end
  endtask

  // Apply one item to the records and return the status that follows it
  task automatic advance_relays(input logic f, input logic [1:0] sel, input logic act,
                                input logic [15:0] dur,
                                output tlrd_pkg::tlrd_result_t status);
    int r;
    status = '0;
    if (f == tlrd_pkg::FUNC_TICK) begin
      for (r = 0; r < tlrd_pkg::NUM_RELAYS; r++) begin
        // pulses count down first, then the on-time timer
        if (set_left[r] != '0) set_left[r] = set_left[r] - 8'd1;
        if (reset_left[r] != '0) reset_left[r] = reset_left[r] - 8'd1;
        if (timer_armed[r] && relay_on[r]) begin
          if (time_left[r] != '0) time_left[r] = time_left[r] - 16'd1;
          if (time_left[r] == '0) drive_relay(r, 1'b0, '0);
        end
      end
    end else if (sel == tlrd_pkg::SEL_NONE) begin
      status.bad_command = 1'b1;
    end else begin
      for (r = 0; r < tlrd_pkg::NUM_RELAYS; r++)
        if (sel[r]) drive_relay(r, act, dur);
    end
    for (r = 0; r < tlrd_pkg::NUM_RELAYS; r++) begin
      status.relay_active[r] = relay_on[r];
      if (cfg.latching_mode) begin
        status.set_drive[r]   = (set_left[r] != '0);
        status.reset_drive[r] = (reset_left[r] != '0);
      end else begin
        status.set_drive[r] = relay_on[r] ^ cfg.output_active_low;
      end
    end
    status.remaining_first    = timer_armed[0] ? time_left[0] : '0;
    status.remaining_second   = timer_armed[1] ? time_left[1] : '0;
    status.activations_first  = on_count[0];
    status.activations_second = on_count[1];
  endtask

  always @(posedge clk) begin : monitor
    tlrd_pkg::tlrd_result_t got;
    tlrd_pkg::tlrd_result_t want;
    tlrd_pkg::tlrd_result_t next_status;
    int r;
    if (rst) begin
      cfg.coil_pulse_ms     = tlrd_pkg::COIL_PULSE_RESET;
      cfg.latching_mode     = 1'b1;
      cfg.output_active_low = 1'b0;
      for (r = 0; r < tlrd_pkg::NUM_RELAYS; r++) begin
        relay_on[r]    = 1'b0;
        timer_armed[r] = 1'b0;
        time_left[r]   = '0;
        on_count[r]    = '0;
        set_left[r]    = '0;
        reset_left[r]  = STARTUP_PULSE_MS[7:0];
      end
      relay_status_q.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      // result transfer: compare with the oldest expectation
      if (out_valid && !out_stall) begin
        got.relay_active       = relay_active;
        got.set_drive          = set_drive;
        got.reset_drive        = reset_drive;
        got.remaining_first    = remaining_first;
        got.remaining_second   = remaining_second;
        got.activations_first  = activations_first;
        got.activations_second = activations_second;
        got.bad_command        = bad_command;
        if (relay_status_q.size() == 0) begin
          report_mismatch("result with nothing expected", 32'(got.relay_active), '0);
        end else begin
          want = relay_status_q.pop_front();
          if (got.relay_active !== want.relay_active)
            report_mismatch("relay_active", 32'(got.relay_active), 32'(want.relay_active));
          if (got.set_drive !== want.set_drive)
            report_mismatch("set_drive", 32'(got.set_drive), 32'(want.set_drive));
          if (got.reset_drive !== want.reset_drive)
            report_mismatch("reset_drive", 32'(got.reset_drive), 32'(want.reset_drive));
          if (got.remaining_first !== want.remaining_first)
            report_mismatch("remaining_first", 32'(got.remaining_first),
                            32'(want.remaining_first));
          if (got.remaining_second !== want.remaining_second)
            report_mismatch("remaining_second", 32'(got.remaining_second),
                            32'(want.remaining_second));
          if (got.activations_first !== want.activations_first)
            report_mismatch("activations_first", got.activations_first,
                            want.activations_first);
          if (got.activations_second !== want.activations_second)
            report_mismatch("activations_second", got.activations_second,
                            want.activations_second);
          if (got.bad_command !== want.bad_command)
            report_mismatch("bad_command", 32'(got.bad_command), 32'(want.bad_command));
        end
        results_seen++;
      end
      // register write; an unknown index changes nothing
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tlrd_pkg::REG_COIL_PULSE_MS:     cfg.coil_pulse_ms     = cfg_data;
          tlrd_pkg::REG_LATCHING_MODE:     cfg.latching_mode     = cfg_data[0];
          tlrd_pkg::REG_OUTPUT_ACTIVE_LOW: cfg.output_active_low = cfg_data[0];
          default: ;
        endcase
      end
      // item transfer: predict its status
      if (in_valid && !in_stall) begin
        advance_relays(func, relay_select, activate, on_time, next_status);
        relay_status_q.push_back(next_status);
      end
    end
    outstanding = relay_status_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the relay driver testbench: clock, reset, stimulus and verdict.
// Depends on tlrd_pkg, timed_latching_relay_driver and tlrd_checker.
`timescale 1ns / 1ps

module tb_top;
  import tlrd_pkg::*;

  localparam int STARTUP_MS     = 50;
  localparam int LIMIT_CYCLES   = 1_000_000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 240;
  localparam int NUM_PHASES     = 8;
  localparam int SETTLE_CYCLES  = 4;

  localparam logic [NUM_RELAYS-1:0] SEL_FIRST  = 2'd1;
  localparam logic [NUM_RELAYS-1:0] SEL_SECOND = 2'd2;
  localparam logic [NUM_RELAYS-1:0] SEL_BOTH   = 2'd3;
  localparam logic [CFG_IDX_W-1:0]  REG_UNUSED = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   func = FUNC_COMMAND;
  logic [NUM_RELAYS-1:0]  relay_select = SEL_NONE;
  logic                   activate = 1'b0;
  logic [DUR_W-1:0]       on_time = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [NUM_RELAYS-1:0]  relay_active;
  logic [NUM_RELAYS-1:0]  set_drive;
  logic [NUM_RELAYS-1:0]  reset_drive;
  logic [DUR_W-1:0]       remaining_first;
  logic [DUR_W-1:0]       remaining_second;
  logic [COUNT_W-1:0]     activations_first;
  logic [COUNT_W-1:0]     activations_second;
  logic                   bad_command;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_COIL_PULSE_MS;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int  fail_count;
  int  outstanding;
  int  results_seen;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  ticks_sent = 0;
  int  bad_sent = 0;
  logic hold_req = 1'b0;
  logic no_gaps = 1'b0;

  always #5 clk = ~clk;

  timed_latching_relay_driver #(.STARTUP_PULSE_MS(STARTUP_MS)) uut (
    .clk, .rst, .in_valid, .in_stall, .func, .relay_select, .activate, .on_time,
    .out_valid, .out_stall, .relay_active, .set_drive, .reset_drive,
    .remaining_first, .remaining_second, .activations_first, .activations_second,
    .bad_command, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  tlrd_checker #(.STARTUP_PULSE_MS(STARTUP_MS)) status_check (
    .clk, .rst, .in_valid, .in_stall, .func, .relay_select, .activate, .on_time,
    .out_valid, .out_stall, .relay_active, .set_drive, .reset_drive,
    .remaining_first, .remaining_second, .activations_first, .activations_second,
    .bad_command, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .outstanding, .results_seen
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count, outstanding);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, quiet stretches, and one long hold-off on request
  initial begin : receiver
    int n;
    int quiet;
    quiet = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (quiet > 0) begin
        quiet--;
        out_stall <= 1'b0;
      end else begin
        n = pick_gap();
        if ($urandom_range(0, 39) == 0) quiet = 30;
        if (n == 0) begin
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b1;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // Offer one item from a falling edge, hold it until transfer, then maybe idle
  int send_quiet = 0;
  task automatic send_item(input logic f, input logic [1:0] sel, input logic act,
                           input logic [15:0] dur);
    int gap;
    in_valid     <= 1'b1;
    func         <= f;
    relay_select <= sel;
    activate     <= act;
    on_time      <= dur;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (f == FUNC_TICK) ticks_sent++;
    else if (sel == SEL_NONE) bad_sent++;
    @(negedge clk);
    gap = 0;
    if (!no_gaps) begin
      if (send_quiet > 0) send_quiet--;
      else if ($urandom_range(0, 49) == 0) send_quiet = 30;
      else gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Mostly ticks and valid commands with short timers; some noise
  task automatic send_random_item();
    int r;
    int d;
    logic [15:0] dur;
    r = $urandom_range(0, 99);
    d = $urandom_range(0, 99);
    if (d < 25) dur = '0;
    else if (d < 75) dur = 16'($urandom_range(1, 20));
    else if (d < 90) dur = 16'($urandom_range(21, 300));
    else if (d < 95) dur = 16'hFFFF;
    else dur = 16'($urandom_range(0, 65535));
    if (r < 50)
      send_item(FUNC_TICK, 2'($urandom), 1'($urandom), 16'($urandom));
    else if (r < 55)
      send_item(FUNC_COMMAND, SEL_NONE, 1'($urandom), dur);
    else
      send_item(FUNC_COMMAND, 2'($urandom_range(1, 3)), $urandom_range(0, 99) < 60, dur);
  endtask

  // Stop offering and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all registers plus the unused index, back to back
  task automatic write_regs(input logic [7:0] coil, input logic latch, input logic alow);
    int i;
    for (i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      case (i)
        0: begin cfg_index <= REG_COIL_PULSE_MS;     cfg_data <= coil; end
        1: begin cfg_index <= REG_LATCHING_MODE;     cfg_data <= {7'($urandom), latch}; end
        2: begin cfg_index <= REG_OUTPUT_ACTIVE_LOW; cfg_data <= {7'($urandom), alow}; end
        default: begin cfg_index <= REG_UNUSED;      cfg_data <= 8'($urandom); end
      endcase
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int ph;
    int n;
    logic [7:0] coil;
    logic latch;
    logic alow;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset settings, startup reset pulses, each select and switch case
    send_item(FUNC_TICK, SEL_BOTH, 1'b1, 16'hFFFF);      // tick ignores the other fields
    send_item(FUNC_COMMAND, SEL_NONE, 1'b1, 16'hFFFF);   // invalid select
    send_item(FUNC_COMMAND, SEL_NONE, 1'b0, 16'h0000);
    send_item(FUNC_COMMAND, SEL_FIRST, 1'b1, 16'd0);     // untimed on
    send_item(FUNC_COMMAND, SEL_SECOND, 1'b1, 16'd2);    // timed on
    send_item(FUNC_TICK, SEL_NONE, 1'b0, 16'd0);
    send_item(FUNC_TICK, SEL_FIRST, 1'b0, 16'h5555);     // second relay times out
    send_item(FUNC_COMMAND, SEL_BOTH, 1'b1, 16'hFFFF);
    send_item(FUNC_COMMAND, SEL_BOTH, 1'b1, 16'd1);      // on again while on
    send_item(FUNC_TICK, SEL_SECOND, 1'b1, 16'hAAAA);    // both time out together
    send_item(FUNC_COMMAND, SEL_FIRST, 1'b0, 16'hFFFF);  // off while already off
    send_item(FUNC_COMMAND, SEL_SECOND, 1'b1, 16'h8000);
    send_item(FUNC_COMMAND, SEL_SECOND, 1'b0, 16'h7FFF); // off clears a running timer
    send_item(FUNC_COMMAND, SEL_BOTH, 1'b0, 16'd0);
    drain();

    // Random phases over several settings, extremes among them
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      coil = COIL_PULSE_RESET;
      latch = 1'b1;
      alow = 1'b0;
      case (ph)
        1: coil = 8'd1;
        2: begin coil = 8'd255; alow = 1'b1; end
        3: coil = 8'd0;                              // no pulse armed
        4: begin coil = 8'd7; latch = 1'b0; end      // level outputs
        5: begin coil = 8'd7; latch = 1'b0; alow = 1'b1; end
        6: begin coil = 8'd3; alow = 1'b1; end       // back to latching
        7: begin
          coil = 8'($urandom_range(1, 255));
          latch = 1'($urandom);
          alow = 1'($urandom);
        end
        default: ;
      endcase
      if (ph > 0) write_regs(coil, latch, alow);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // long hold-off on the result side while items keep coming
        if (ph == 2 && n == 100) begin
          hold_req = 1'b1;
          no_gaps = 1'b1;
        end
        if (ph == 2 && n == 140) no_gaps = 1'b0;
        // sender waits for every owed result mid-phase
        if (ph == 4 && n == 120) drain();
        send_random_item();
      end
      drain();
    end

    $display("Sent %0d items (%0d ticks, %0d invalid selects) over %0d register settings;",
             items_sent, ticks_sent, bad_sent, NUM_PHASES);
    $display("checked %0d relay status results in %0d cycles.", results_seen, cycle_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/tlrd_pkg.sv
design/tlrd_relay.sv
design/tlrd_out_queue.sv
design/timed_latching_relay_driver.sv
test/tlrd_checker.sv
test/tb_top.sv
